// ===== src/ffha_pkg.sv =====
// Shared constants, types and state codes for the first-fit heap allocator.
package ffha_pkg;

	// arena and header geometry
	localparam int POOL_BYTES      = 4096;
	localparam int GRANULE_BYTES   = 4;
	localparam int HDR_BYTES       = 8;
	localparam int SPLIT_MIN_BYTES = 12;
	localparam int HDR_WORDS       = POOL_BYTES / 4;
	localparam int WALK_LIMIT      = HDR_WORDS + 1;
	localparam int ARENA_MIN       = 16;

	// field and internal widths
	localparam int OFF_W   = 13;
	localparam int SUM_W   = OFF_W + 2;
	localparam int WADDR_W = OFF_W - 1;
	localparam int MEM_AW  = $clog2(HDR_WORDS);
	localparam int CNT_W   = $clog2(WALK_LIMIT + 1);

	// one header link word: valid flag plus byte offset
	typedef struct packed {
		logic             vld;
		logic [OFF_W-1:0] off;
	} link_t;

	localparam int LINK_W = $bits(link_t);

	// response codes
	typedef enum logic [1:0] {
		ST_ALLOC  = 2'd0,
		ST_OOM    = 2'd1,
		ST_FREED  = 2'd2,
		ST_REJECT = 2'd3
	} status_t;

	// request kinds
	typedef enum logic {
		REQ_ALLOC = 1'b0,
		REQ_FREE  = 1'b1
	} req_kind_t;

	// sequencer states
	typedef enum logic [5:0] {
		S_INIT0, S_INIT1, S_IDLE,
		S_A_LOOP, S_A_NX, S_A_BK, S_A_W0, S_A_W1, S_A_W2, S_A_W3, S_A_W4,
		S_T_W0, S_T_W1, S_T_W2,
		S_F_CHK, S_F_NV, S_F_PV, S_F_BS, S_F_T, S_F_TB, S_F_PB, S_F_PBD,
		S_F_G1, S_F_G2, S_F_GW, S_F_GB, S_F_WB, S_F_END, S_F_END2,
		S_P0, S_P1, S_P2, S_DONE
	} state_t;

	// result handed from the sequencer to the response register
	typedef struct packed {
		status_t          status;
		logic [OFF_W-1:0] data_offset;
	} res_t;

	// header memory access for one cycle
	typedef struct packed {
		logic              we;
		logic [MEM_AW-1:0] waddr;
		link_t             wdata;
		logic              re;
		logic [MEM_AW-1:0] raddr;
	} mem_req_t;

endpackage

// ===== src/ffha_ifs.sv =====
// Valid/ready channel interfaces for requests, responses and arena configuration.
interface ffha_req_if;
	logic                         valid;
	logic                         ready;
	logic                         req_type;
	logic [ffha_pkg::OFF_W-1:0]   alloc_bytes;
	logic [ffha_pkg::OFF_W-1:0]   release_offset;
	modport source (output valid, req_type, alloc_bytes, release_offset, input ready);
	modport sink   (input valid, req_type, alloc_bytes, release_offset, output ready);
endinterface

interface ffha_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [1:0]                   status;
	logic [ffha_pkg::OFF_W-1:0]   data_offset;
	modport source (output valid, status, data_offset, input ready);
	modport sink   (input valid, status, data_offset, output ready);
endinterface

interface ffha_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [ffha_pkg::OFF_W-1:0]   arena_bytes;
	modport source (output valid, arena_bytes, input ready);
	modport sink   (input valid, arena_bytes, output ready);
endinterface

// ===== src/ffha_ram.sv =====
// Single-port-write, single-port-read synchronous RAM with registered read data.
module ffha_ram #(
	parameter int AW = 10,
	parameter int DW = 14
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [2**AW];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== src/ffha_ctrl.sv =====
// Sequencer that walks and rewrites the header chain for allocate and free requests.
module ffha_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	ffha_req_if.sink           req,
	ffha_cfg_if.sink           cfg,
	output ffha_pkg::mem_req_t mreq,
	input  ffha_pkg::link_t    mrdata,
	output logic               res_vld,
	output ffha_pkg::res_t     res,
	input  logic               res_free
);

	localparam logic [ffha_pkg::OFF_W-1:0] HDR  = ffha_pkg::OFF_W'(ffha_pkg::HDR_BYTES);
	localparam logic [ffha_pkg::SUM_W-1:0] GMSK = ffha_pkg::SUM_W'(ffha_pkg::GRANULE_BYTES - 1);

	ffha_pkg::state_t state_q, state_d;

	logic [ffha_pkg::OFF_W-1:0] arena_q, qs_q;
	logic [ffha_pkg::OFF_W-1:0] g_q, n_q, nn_q, newq_q, node_q, pred_q, link_q;
	logic [ffha_pkg::SUM_W-1:0] size_q;
	logic [ffha_pkg::CNT_W-1:0] cnt_q;
	logic                       have_q, split_q, pr_free_q, rd_oob_s1;
	ffha_pkg::link_t            nv_q, pv_q, bs_q, t_q, t2_q;
	ffha_pkg::res_t             res_q;

	// read data, out-of-store words read as null
	ffha_pkg::link_t            rd;
	assign rd = rd_oob_s1 ? '0 : mrdata;

	// word addresses of back and next links for a node offset
	function automatic logic [ffha_pkg::WADDR_W-1:0] back_a(input logic [ffha_pkg::OFF_W-1:0] x);
		back_a = {1'b0, x[ffha_pkg::OFF_W-1:2]};
	endfunction

	function automatic logic [ffha_pkg::WADDR_W-1:0] next_a(input logic [ffha_pkg::OFF_W-1:0] x);
		next_a = {1'b0, x[ffha_pkg::OFF_W-1:2]} + ffha_pkg::WADDR_W'(1);
	endfunction

	function automatic ffha_pkg::link_t mk(input logic [ffha_pkg::OFF_W-1:0] x);
		mk.vld = 1'b1;
		mk.off = x;
	endfunction

	// arithmetic on the walk node
	logic [ffha_pkg::SUM_W-1:0] size_w, g_hdr, g_end, n_w, cap_w;
	logic                       walk_done, found, p_hit;
	logic [ffha_pkg::OFF_W-1:0] arena_w, q_sel;
	assign size_w    = (ffha_pkg::SUM_W'(req.alloc_bytes) + GMSK) & ~GMSK;
	assign g_hdr     = ffha_pkg::SUM_W'(g_q) + ffha_pkg::SUM_W'(HDR);
	assign g_end     = g_hdr + size_q;
	assign n_w       = ffha_pkg::SUM_W'(n_q);
	assign cap_w     = (n_w >= g_hdr) ? n_w - g_hdr : '0;
	assign found     = !rd.vld && (cap_w >= size_q);
	assign walk_done = (cnt_q >= ffha_pkg::CNT_W'(ffha_pkg::WALK_LIMIT));
	assign p_hit     = !rd.vld || (rd.off == g_q);
	assign q_sel     = have_q ? newq_q : g_q;

	// arena length clamp
	always_comb begin
		if (cfg.arena_bytes < ffha_pkg::OFF_W'(ffha_pkg::ARENA_MIN)) begin
			arena_w = ffha_pkg::OFF_W'(ffha_pkg::ARENA_MIN);
		end else if (cfg.arena_bytes > ffha_pkg::OFF_W'(ffha_pkg::POOL_BYTES)) begin
			arena_w = ffha_pkg::OFF_W'(ffha_pkg::POOL_BYTES);
		end else begin
			arena_w = cfg.arena_bytes;
		end
	end

	// free request checks
	logic [ffha_pkg::OFF_W-1:0] p_w;
	logic                       bad_off, bad_hdr;
	assign p_w     = req.release_offset;
	assign bad_off = (p_w < HDR) || (p_w[1:0] != 2'b00) || (p_w > arena_q);
	assign bad_hdr = !nv_q.vld || (nv_q.off > arena_q) || !rd.vld || (rd.off > nv_q.off);

	// memory access helper signals
	logic                         we_d, re_d;
	logic [ffha_pkg::WADDR_W-1:0] wa_d, ra_d;
	ffha_pkg::link_t              wd_d;

	assign req.ready  = (state_q == ffha_pkg::S_IDLE) && !cfg.valid;
	assign cfg.ready  = (state_q == ffha_pkg::S_IDLE);
	assign res_vld    = (state_q == ffha_pkg::S_DONE) && res_free;
	assign res        = res_q;

	assign mreq.we    = we_d && (wa_d < ffha_pkg::WADDR_W'(ffha_pkg::HDR_WORDS));
	assign mreq.waddr = wa_d[ffha_pkg::MEM_AW-1:0];
	assign mreq.wdata = wd_d;
	assign mreq.re    = re_d;
	assign mreq.raddr = ra_d[ffha_pkg::MEM_AW-1:0];

	// next state and memory commands
	always_comb begin
		state_d = state_q;
		we_d    = 1'b0;
		re_d    = 1'b0;
		wa_d    = '0;
		ra_d    = '0;
		wd_d    = '0;
		case (state_q)
			ffha_pkg::S_INIT0: begin
				we_d = 1'b1; wa_d = next_a('0); wd_d = '0;
				state_d = ffha_pkg::S_INIT1;
			end
			ffha_pkg::S_INIT1: begin
				we_d = 1'b1; wa_d = back_a('0); wd_d = mk('0);
				state_d = ffha_pkg::S_IDLE;
			end
			ffha_pkg::S_IDLE: begin
				if (cfg.valid) begin
					state_d = ffha_pkg::S_INIT0;
				end else if (req.valid) begin
					if (req.req_type == ffha_pkg::REQ_ALLOC) begin
						state_d = ffha_pkg::S_A_LOOP;
					end else if (bad_off) begin
						state_d = ffha_pkg::S_DONE;
					end else begin
						state_d = ffha_pkg::S_F_CHK;
					end
				end
			end
			// allocation walk
			ffha_pkg::S_A_LOOP: begin
				if (walk_done) begin
					state_d = ffha_pkg::S_DONE;
				end else begin
					re_d = 1'b1; ra_d = next_a(g_q);
					state_d = ffha_pkg::S_A_NX;
				end
			end
			ffha_pkg::S_A_NX: begin
				if (!rd.vld) begin
					state_d = (g_end >= ffha_pkg::SUM_W'(arena_q)) ? ffha_pkg::S_DONE
					                                              : ffha_pkg::S_T_W0;
				end else begin
					re_d = 1'b1; ra_d = back_a(g_q);
					state_d = ffha_pkg::S_A_BK;
				end
			end
			ffha_pkg::S_A_BK: begin
				state_d = found ? ffha_pkg::S_P0 : ffha_pkg::S_A_LOOP;
			end
			ffha_pkg::S_A_W0: begin
				we_d = 1'b1; wa_d = back_a(g_q); wd_d = mk(pred_q);
				state_d = split_q ? ffha_pkg::S_A_W1 : ffha_pkg::S_DONE;
			end
			ffha_pkg::S_A_W1: begin
				we_d = 1'b1; wa_d = next_a(g_q); wd_d = mk(nn_q);
				state_d = ffha_pkg::S_A_W2;
			end
			ffha_pkg::S_A_W2: begin
				we_d = 1'b1; wa_d = next_a(nn_q); wd_d = mk(n_q);
				state_d = ffha_pkg::S_A_W3;
			end
			ffha_pkg::S_A_W3: begin
				we_d = 1'b1; wa_d = back_a(nn_q); wd_d = '0;
				state_d = ffha_pkg::S_A_W4;
			end
			ffha_pkg::S_A_W4: begin
				we_d = 1'b1; wa_d = back_a(n_q); wd_d = mk(nn_q);
				state_d = ffha_pkg::S_DONE;
			end
			// carve from the tail
			ffha_pkg::S_T_W0: begin
				we_d = 1'b1; wa_d = next_a(g_q); wd_d = mk(nn_q);
				state_d = ffha_pkg::S_T_W1;
			end
			ffha_pkg::S_T_W1: begin
				we_d = 1'b1; wa_d = back_a(nn_q); wd_d = mk(g_q);
				state_d = ffha_pkg::S_T_W2;
			end
			ffha_pkg::S_T_W2: begin
				we_d = 1'b1; wa_d = next_a(nn_q); wd_d = '0;
				state_d = ffha_pkg::S_DONE;
			end
			// free: header checks
			ffha_pkg::S_F_CHK: begin
				re_d = 1'b1; ra_d = next_a(node_q);
				state_d = ffha_pkg::S_F_NV;
			end
			ffha_pkg::S_F_NV: begin
				re_d = 1'b1; ra_d = back_a(node_q);
				state_d = ffha_pkg::S_F_PV;
			end
			ffha_pkg::S_F_PV: begin
				if (bad_hdr) begin
					state_d = ffha_pkg::S_DONE;
				end else begin
					re_d = 1'b1; ra_d = back_a(nv_q.off);
					state_d = ffha_pkg::S_F_BS;
				end
			end
			ffha_pkg::S_F_BS: begin
				re_d = 1'b1; ra_d = next_a(nv_q.off);
				state_d = ffha_pkg::S_F_T;
			end
			// free: merge with successor
			ffha_pkg::S_F_T: begin
				if (!bs_q.vld || !rd.vld) begin
					we_d = 1'b1; wa_d = next_a(node_q); wd_d = rd;
					state_d = rd.vld ? ffha_pkg::S_F_TB : ffha_pkg::S_F_PB;
				end else begin
					state_d = ffha_pkg::S_F_PB;
				end
			end
			ffha_pkg::S_F_TB: begin
				we_d = 1'b1; wa_d = back_a(t_q.off); wd_d = mk(node_q);
				state_d = ffha_pkg::S_F_PB;
			end
			// free: merge into predecessor
			ffha_pkg::S_F_PB: begin
				re_d = 1'b1; ra_d = back_a(pv_q.off);
				state_d = ffha_pkg::S_F_PBD;
			end
			ffha_pkg::S_F_PBD: begin
				if (!rd.vld) begin
					re_d = 1'b1; ra_d = next_a(pv_q.off);
					state_d = ffha_pkg::S_F_G1;
				end else begin
					state_d = ffha_pkg::S_F_END;
				end
			end
			ffha_pkg::S_F_G1: begin
				if (rd.vld) begin
					re_d = 1'b1; ra_d = next_a(rd.off);
					state_d = ffha_pkg::S_F_G2;
				end else begin
					state_d = ffha_pkg::S_F_GW;
				end
			end
			ffha_pkg::S_F_G2: begin
				state_d = ffha_pkg::S_F_GW;
			end
			ffha_pkg::S_F_GW: begin
				we_d = 1'b1; wa_d = next_a(g_q); wd_d = t2_q;
				state_d = t2_q.vld ? ffha_pkg::S_F_GB : ffha_pkg::S_P0;
			end
			ffha_pkg::S_F_GB: begin
				we_d = 1'b1; wa_d = back_a(t2_q.off); wd_d = mk(g_q);
				state_d = ffha_pkg::S_F_END;
			end
			ffha_pkg::S_F_WB: begin
				we_d = 1'b1; wa_d = back_a(g_q); wd_d = mk(pred_q);
				state_d = ffha_pkg::S_F_END;
			end
			ffha_pkg::S_F_END: begin
				re_d = 1'b1; ra_d = next_a(g_q);
				state_d = ffha_pkg::S_F_END2;
			end
			ffha_pkg::S_F_END2: begin
				if (rd.vld) begin
					we_d = 1'b1; wa_d = back_a(g_q); wd_d = '0;
				end
				state_d = ffha_pkg::S_DONE;
			end
			// predecessor search from node 0
			ffha_pkg::S_P0: begin
				if (g_q == '0) begin
					state_d = pr_free_q ? ffha_pkg::S_F_WB : ffha_pkg::S_A_W0;
				end else begin
					state_d = ffha_pkg::S_P1;
				end
			end
			ffha_pkg::S_P1: begin
				if (walk_done) begin
					state_d = pr_free_q ? ffha_pkg::S_F_WB : ffha_pkg::S_A_W0;
				end else begin
					re_d = 1'b1; ra_d = next_a(link_q);
					state_d = ffha_pkg::S_P2;
				end
			end
			ffha_pkg::S_P2: begin
				if (p_hit) begin
					state_d = pr_free_q ? ffha_pkg::S_F_WB : ffha_pkg::S_A_W0;
				end else begin
					state_d = ffha_pkg::S_P1;
				end
			end
			ffha_pkg::S_DONE: begin
				if (res_free) begin
					state_d = ffha_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ffha_pkg::S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ffha_pkg::S_INIT0;
			arena_q   <= ffha_pkg::OFF_W'(ffha_pkg::POOL_BYTES);
			qs_q      <= '0;
			rd_oob_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (re_d) begin
				rd_oob_s1 <= (ra_d >= ffha_pkg::WADDR_W'(ffha_pkg::HDR_WORDS));
			end
			case (state_q)
				ffha_pkg::S_IDLE: begin
					if (cfg.valid) begin
						arena_q <= arena_w;
						qs_q    <= '0;
					end
				end
				ffha_pkg::S_A_LOOP: begin
					if (walk_done) begin
						qs_q <= have_q ? newq_q : '0;
					end
				end
				ffha_pkg::S_A_NX: begin
					if (!rd.vld) begin
						qs_q <= (g_end >= ffha_pkg::SUM_W'(arena_q)) ? q_sel
						                                           : (have_q ? newq_q : g_end[ffha_pkg::OFF_W-1:0]);
					end
				end
				ffha_pkg::S_A_W0: begin
					if (!split_q) begin
						qs_q <= have_q ? newq_q : n_q;
					end
				end
				ffha_pkg::S_A_W4: begin
					qs_q <= have_q ? newq_q : nn_q;
				end
				ffha_pkg::S_F_END2: begin
					if (qs_q > g_q) begin
						qs_q <= g_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// payload registers of the request in flight
	always_ff @(posedge clk) begin
		case (state_q)
			ffha_pkg::S_IDLE: begin
				g_q       <= qs_q;
				size_q    <= size_w;
				have_q    <= 1'b0;
				cnt_q     <= '0;
				pr_free_q <= (req.req_type == ffha_pkg::REQ_FREE);
				node_q    <= p_w - HDR;
				res_q     <= '{ffha_pkg::ST_REJECT, '0};
				if (req.req_type == ffha_pkg::REQ_ALLOC) begin
					res_q.status <= ffha_pkg::ST_OOM;
				end
			end
			ffha_pkg::S_A_NX: begin
				n_q <= rd.off;
				if (!rd.vld) begin
					nn_q <= g_end[ffha_pkg::OFF_W-1:0];
					if (g_end < ffha_pkg::SUM_W'(arena_q)) begin
						res_q <= '{ffha_pkg::ST_ALLOC, g_hdr[ffha_pkg::OFF_W-1:0]};
					end
				end
			end
			ffha_pkg::S_A_BK: begin
				if (found) begin
					split_q <= (cap_w - size_q) >= ffha_pkg::SUM_W'(ffha_pkg::SPLIT_MIN_BYTES);
					nn_q    <= g_end[ffha_pkg::OFF_W-1:0];
					res_q   <= '{ffha_pkg::ST_ALLOC, g_hdr[ffha_pkg::OFF_W-1:0]};
					cnt_q   <= '0;
					link_q  <= '0;
					pred_q  <= '0;
				end else begin
					if (!rd.vld && !have_q) begin
						newq_q <= g_q;
						have_q <= 1'b1;
					end
					g_q   <= n_q;
					cnt_q <= cnt_q + ffha_pkg::CNT_W'(1);
				end
			end
			ffha_pkg::S_A_W1: begin
				if (!have_q) begin
					newq_q <= nn_q;
					have_q <= 1'b1;
				end
			end
			ffha_pkg::S_F_NV: nv_q <= rd;
			ffha_pkg::S_F_PV: begin
				pv_q <= rd;
				if (!bad_hdr) begin
					res_q.status <= ffha_pkg::ST_FREED;
				end
			end
			ffha_pkg::S_F_BS: bs_q <= rd;
			ffha_pkg::S_F_T:  t_q  <= rd;
			ffha_pkg::S_F_PB: g_q  <= node_q;
			ffha_pkg::S_F_PBD: begin
				if (!rd.vld) begin
					g_q <= pv_q.off;
				end
			end
			ffha_pkg::S_F_G1: begin
				if (!rd.vld) begin
					t2_q <= '0;
				end
			end
			ffha_pkg::S_F_G2: t2_q <= rd;
			ffha_pkg::S_F_GW: begin
				cnt_q  <= '0;
				link_q <= '0;
				pred_q <= '0;
			end
			ffha_pkg::S_P1: begin
				if (walk_done) begin
					pred_q <= link_q;
				end
			end
			ffha_pkg::S_P2: begin
				if (p_hit) begin
					pred_q <= link_q;
				end else begin
					link_q <= rd.off;
					cnt_q  <= cnt_q + ffha_pkg::CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// the header memory is never read and written in the same cycle
	assert property (@(posedge clk) disable iff (!arst_n) !(we_d && re_d))
		else $error("header read and write collide");

	// walk counters never pass the step limit (the counter is loaded once the sequencer is idle)
	assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown(cnt_q) |-> cnt_q <= ffha_pkg::CNT_W'(ffha_pkg::WALK_LIMIT))
		else $error("walk counter overran its limit");

	// a granted offset always lies past a header
	assert property (@(posedge clk) disable iff (!arst_n)
		res_vld && res.status == ffha_pkg::ST_ALLOC |-> res.data_offset >= HDR)
		else $error("granted offset inside a header");

	// non-grant responses carry a zero offset
	assert property (@(posedge clk) disable iff (!arst_n)
		res_vld && res.status != ffha_pkg::ST_ALLOC |-> res.data_offset == '0)
		else $error("offset set on a non-grant response");

	// a configuration transfer always rebuilds the chain head next
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid && cfg.ready |=> state_q == ffha_pkg::S_INIT0)
		else $error("arena write did not restart the chain");

endmodule

// ===== src/first_fit_heap_allocator.sv =====
// First-fit heap allocator: top level with header RAM, sequencer and response register.
// Allocate walks the chain node by node from the quick-start node; a free-node hit adds
// a predecessor search from node 0 and, when the remainder is large enough, a split.
// Free: a bad offset is rejected before any header read, else headers are checked and merged.
// Throughput: one request at a time; a new one is taken while the last response waits.
// Reset: states S_INIT0 and S_INIT1 rebuild node 0 as the empty tail; the arena length resets to 4096.
module first_fit_heap_allocator (
	input  logic      clk,
	input  logic      arst_n,
	ffha_req_if.sink  req,
	ffha_rsp_if.source rsp,
	ffha_cfg_if.sink  cfg
);

	ffha_pkg::mem_req_t mreq;
	ffha_pkg::link_t    mrdata;
	ffha_pkg::res_t     res, rsp_q;
	logic               res_vld, res_free, rsp_vld_q;

	// header memory
	ffha_ram #(
		.AW(ffha_pkg::MEM_AW),
		.DW(ffha_pkg::LINK_W)
	) u_ram (
		.clk   (clk),
		.we    (mreq.we),
		.waddr (mreq.waddr),
		.wdata (mreq.wdata),
		.re    (mreq.re),
		.raddr (mreq.raddr),
		.rdata (mrdata)
	);

	// chain sequencer
	ffha_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.cfg      (cfg),
		.mreq     (mreq),
		.mrdata   (mrdata),
		.res_vld  (res_vld),
		.res      (res),
		.res_free (res_free)
	);

	// response register: free when empty or being taken this cycle
	assign res_free = !rsp_vld_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (res_free) begin
			rsp_vld_q <= res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (res_vld) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid       = rsp_vld_q;
	assign rsp.status      = rsp_q.status;
	assign rsp.data_offset = rsp_q.data_offset;

endmodule

// ===== sim/ffha_checker.sv =====
// Response checker for the first-fit heap allocator: header model, expected queue, compare.
module ffha_checker (
	input  logic clk,
	input  logic arst_n,
	ffha_req_if  req,
	ffha_rsp_if  rsp,
	ffha_cfg_if  cfg,
	output int   errors,
	output int   outstanding
);
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	// model state
	link_t hdr [HDR_WORDS];
	int    quick_node;
	int    arena_len;
	res_t  expected_rsp [$];

	function automatic link_t rd_word(int w);
		return (w < HDR_WORDS) ? hdr[w] : link_t'('0);
	endfunction

	function automatic void wr_word(int w, link_t v);
		if (w < HDR_WORDS) hdr[w] = v;
	endfunction

	function automatic link_t back_of(int n);
		return rd_word(n >> 2);
	endfunction

	function automatic link_t next_of(int n);
		return rd_word((n >> 2) + 1);
	endfunction

	function automatic link_t mk_link(logic [31:0] o);
		link_t l;
		l.vld = 1'b1;
		l.off = o[OFF_W-1:0];
		return l;
	endfunction

	function automatic void rebuild_chain();
		quick_node = 0;
		wr_word(1, link_t'('0));
		wr_word(0, mk_link(0));
	endfunction

	// node whose next link points at g, searched from node 0
	function automatic int find_prev_node(int g);
		int    cur;
		link_t nx;
		cur = 0;
		if (g == 0) return 0;
		for (int s = 0; s < WALK_LIMIT; s++) begin
			nx = next_of(cur);
			if (!nx.vld || nx.off == g) return cur;
			cur = nx.off;
		end
		return cur;
	endfunction

	// first-fit allocation walk from the quick-start node
	function automatic res_t grant_block(int req_bytes);
		int    size, g, newq, steps, n, cap, ret, nn;
		bit    have;
		link_t nx, bk;
		res_t  r;
		size = (req_bytes + GRANULE_BYTES - 1) & ~(GRANULE_BYTES - 1);
		g = quick_node;
		newq = 0;
		have = 0;
		r.status = ST_OOM;
		r.data_offset = '0;
		for (steps = 0; steps < WALK_LIMIT; steps++) begin
			nx = next_of(g);
			if (!nx.vld) break;
			n = nx.off;
			bk = back_of(g);
			if (!bk.vld) begin
				cap = (n >= g + HDR_BYTES) ? n - g - HDR_BYTES : 0;
				if (cap >= size) begin
					wr_word(g >> 2, mk_link(find_prev_node(g)));
					ret = g + HDR_BYTES;
					if (cap - size >= SPLIT_MIN_BYTES) begin
						// split off the remainder as a new free node
						nn = ret + size;
						wr_word((g >> 2) + 1, mk_link(nn));
						wr_word((nn >> 2) + 1, mk_link(n));
						wr_word(nn >> 2, link_t'('0));
						wr_word(n >> 2, mk_link(nn));
						if (!have) begin
							newq = nn;
							have = 1;
						end
					end else if (!have) begin
						newq = n;
						have = 1;
					end
					quick_node = newq;
					r.status = ST_ALLOC;
					r.data_offset = ret[OFF_W-1:0];
					return r;
				end
				if (!have) begin
					newq = g;
					have = 1;
				end
			end
			g = n;
		end
		if (steps >= WALK_LIMIT) begin
			quick_node = have ? newq : 0;
			return r;
		end
		if (g + HDR_BYTES + size >= arena_len) begin
			quick_node = have ? newq : g;
			return r;
		end
		// carve from the tail
		ret = g + HDR_BYTES;
		nn = ret + size;
		wr_word((g >> 2) + 1, mk_link(nn));
		wr_word(nn >> 2, mk_link(g));
		wr_word((nn >> 2) + 1, link_t'('0));
		quick_node = have ? newq : nn;
		r.status = ST_ALLOC;
		r.data_offset = ret[OFF_W-1:0];
		return r;
	endfunction

	// validate, release and coalesce
	function automatic res_t release_block(int p);
		int    node, g, succ;
		link_t nv, pv, a, b, t;
		res_t  r;
		r.status = ST_REJECT;
		r.data_offset = '0;
		if (p < HDR_BYTES || (p % 4) != 0 || p > arena_len) return r;
		node = p - HDR_BYTES;
		nv = next_of(node);
		pv = back_of(node);
		if (!nv.vld || nv.off > arena_len) return r;
		if (!pv.vld || pv.off > nv.off) return r;
		r.status = ST_FREED;
		// successor free or tail
		succ = nv.off;
		a = back_of(succ);
		b = next_of(succ);
		if (!a.vld || !b.vld) begin
			t = b;
			wr_word((node >> 2) + 1, t);
			if (t.vld) wr_word(t.off >> 2, mk_link(node));
		end
		g = node;
		// predecessor free
		a = back_of(pv.off);
		if (!a.vld) begin
			g = pv.off;
			t = next_of(g);
			t = t.vld ? next_of(t.off) : link_t'('0);
			wr_word((g >> 2) + 1, t);
			if (t.vld) wr_word(t.off >> 2, mk_link(g));
			else wr_word(g >> 2, mk_link(find_prev_node(g)));
		end
		t = next_of(g);
		if (t.vld) wr_word(g >> 2, link_t'('0));
		if (quick_node > g) quick_node = g;
		return r;
	endfunction

	// watch transfers: compare responses, apply config, predict requests
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		int   v;
		if (!arst_n) begin
			for (int i = 0; i < HDR_WORDS; i++) hdr[i] = '0;
			arena_len = POOL_BYTES;
			rebuild_chain();
			expected_rsp.delete();
			errors <= 0;
			outstanding <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (expected_rsp.size() == 0) begin
					$display("%0t: response with nothing expected: status %0d offset %0d",
						$time, rsp.status, rsp.data_offset);
					errors <= errors + 1;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp.status !== want.status || rsp.data_offset !== want.data_offset) begin
						$display("%0t: mismatch: expected status %0d offset %0d, got status %0d offset %0d",
							$time, want.status, want.data_offset, rsp.status, rsp.data_offset);
						errors <= errors + 1;
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				v = cfg.arena_bytes;
				if (v < ARENA_MIN) v = ARENA_MIN;
				if (v > POOL_BYTES) v = POOL_BYTES;
				arena_len = v;
				rebuild_chain();
			end
			if (req.valid && req.ready) begin
				if (req.req_type == REQ_ALLOC) expected_rsp.push_back(grant_block(req.alloc_bytes));
				else expected_rsp.push_back(release_block(req.release_offset));
			end
			outstanding <= expected_rsp.size();
		end
	end

endmodule

// ===== sim/first_fit_heap_allocator_test.sv =====
// Stimulus and verdict for the first-fit heap allocator test bench.
module first_fit_heap_allocator_test;
	timeunit 1ns;
	timeprecision 1ps;
	import ffha_pkg::*;

	logic clk;
	logic arst_n;
	int   errors;
	int   outstanding;
	int   send_idle;
	int   stall_pct;
	int   arena_now;

	// offsets granted and not yet released, and every offset ever granted
	logic [OFF_W-1:0] live [$];
	logic [OFF_W-1:0] granted_ever [$];
	bit               seen [1 << OFF_W];

	ffha_req_if req_if ();
	ffha_rsp_if rsp_if ();
	ffha_cfg_if cfg_if ();

	first_fit_heap_allocator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if),
		.cfg    (cfg_if)
	);

	ffha_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_if),
		.rsp         (rsp_if),
		.cfg         (cfg_if),
		.errors      (errors),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// response side back-pressure
	always @(posedge clk) begin
		rsp_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	// track grants seen on the response channel
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready && rsp_if.status == ST_ALLOC) begin
			live.push_back(rsp_if.data_offset);
			if (!seen[rsp_if.data_offset]) begin
				seen[rsp_if.data_offset] = 1'b1;
				granted_ever.push_back(rsp_if.data_offset);
			end
		end
	end

	// one request transfer, with a random gap first
	task automatic send_req(req_kind_t kind, int bytes, int offs);
		if ($urandom_range(99) < send_idle) begin
			req_if.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		req_if.valid <= 1'b1;
		req_if.req_type <= kind;
		req_if.alloc_bytes <= bytes[OFF_W-1:0];
		req_if.release_offset <= offs[OFF_W-1:0];
		do @(posedge clk); while (!req_if.ready);
	endtask

	task automatic wait_idle();
		req_if.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
	endtask

	task automatic write_arena(int v);
		wait_idle();
		cfg_if.valid <= 1'b1;
		cfg_if.arena_bytes <= v[OFF_W-1:0];
		do @(posedge clk); while (!cfg_if.ready);
		cfg_if.valid <= 1'b0;
		arena_now = (v < ARENA_MIN) ? ARENA_MIN : (v > POOL_BYTES) ? POOL_BYTES : v;
		live.delete();
	endtask

	function automatic int live_at(int i);
		return (i < live.size()) ? int'(live[i]) : HDR_BYTES;
	endfunction

	// offset that fails the range or alignment check
	function automatic int bad_offset();
		case ($urandom_range(2))
			0: return $urandom_range(0, HDR_BYTES - 1);
			1: return ($urandom_range(8191) & ~3) | $urandom_range(1, 3);
			default: return $urandom_range(arena_now + 1, 8191);
		endcase
	endfunction

	task automatic random_item();
		int r, k, sz;
		r = $urandom_range(99);
		if (live.size() == 0 || r < 50) begin
			k = $urandom_range(99);
			if (k < 5) sz = $urandom_range(8191);
			else if (k < 15) sz = $urandom_range(arena_now);
			else sz = $urandom_range(48);
			send_req(REQ_ALLOC, sz, 0);
		end else if (r < 85) begin
			k = $urandom_range(live.size() - 1);
			send_req(REQ_FREE, 0, live[k]);
			live.delete(k);
		end else if (r < 93 && granted_ever.size() != 0) begin
			// stale or double release
			send_req(REQ_FREE, 0, granted_ever[$urandom_range(granted_ever.size() - 1)]);
		end else begin
			send_req(REQ_FREE, 0, bad_offset());
		end
	endtask

	initial begin
		int held [6];
		int settings [8];
		req_if.valid = 1'b0;
		req_if.req_type = REQ_ALLOC;
		req_if.alloc_bytes = '0;
		req_if.release_offset = '0;
		rsp_if.ready = 1'b0;
		cfg_if.valid = 1'b0;
		cfg_if.arena_bytes = '0;
		send_idle = 0;
		stall_pct = 0;
		arena_now = POOL_BYTES;
		arst_n = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: sizes at the edges, split and tail carving, merges, rejects
		send_req(REQ_ALLOC, 0, 0);
		send_req(REQ_ALLOC, 1, 0);
		send_req(REQ_ALLOC, 13, 0);
		send_req(REQ_ALLOC, 8191, 0);
		send_req(REQ_ALLOC, 4096, 0);
		send_req(REQ_ALLOC, 20, 0);
		send_req(REQ_ALLOC, 20, 0);
		send_req(REQ_ALLOC, 20, 0);
		wait_idle();
		for (int i = 0; i < 6; i++) held[i] = live_at(i);
		send_req(REQ_FREE, 0, held[3]);
		send_req(REQ_FREE, 0, held[3]);
		send_req(REQ_FREE, 0, held[4]);
		send_req(REQ_ALLOC, 8, 0);
		send_req(REQ_FREE, 0, held[1]);
		send_req(REQ_FREE, 0, held[2]);
		send_req(REQ_FREE, 0, 4);
		send_req(REQ_FREE, 0, 10);
		send_req(REQ_FREE, 0, 8188);
		send_req(REQ_FREE, 0, held[5]);
		send_req(REQ_FREE, 0, held[0]);
		send_req(REQ_ALLOC, 4072, 0);
		wait_idle();
		live.delete();

		// random phases over several arena lengths and idling patterns
		settings = '{0, 100, 8191, 600, 17, 4097, 0, 4096};
		settings[6] = $urandom_range(ARENA_MIN, POOL_BYTES);
		for (int ph = 0; ph < 9; ph++) begin
			if (ph > 0) write_arena(settings[ph - 1]);
			case (ph % 4)
				0: begin send_idle = 0;  stall_pct = 0;  end
				1: begin send_idle = 55; stall_pct = 0;  end
				2: begin send_idle = 0;  stall_pct = 55; end
				default: begin send_idle = 30; stall_pct = 30; end
			endcase
			for (int n = 0; n < 192; n++) random_item();
		end

		wait_idle();
		repeat (100) @(posedge clk);
		if (errors == 0 && outstanding == 0) $display("first_fit_heap_allocator test passed");
		else $display("first_fit_heap_allocator test failed");
		$finish;
	end

	// run limit
	initial begin
		#200_000_000;
		$display("first_fit_heap_allocator test failed");
		$finish;
	end

endmodule
